// ===== hw/rtl/tdr_pkg.sv =====
// Types, constants and the control store shared by the thruster conditioner.
// Depends on nothing; imported by tdr_div and thrust_desaturate_and_ramp_unit.
`default_nettype none

package tdr_pkg;

    localparam int MAXCH = 8;

    // Opcode of an input item
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register index on the configuration port (paddr[2])
    localparam logic REG_LIMIT = 1'b0;
    localparam logic REG_STEP  = 1'b1;

    localparam logic [14:0] LIMIT_RESET = 15'd32767;
    localparam logic [14:0] STEP_RESET  = 15'd1024;

    // Shared divider: 30-bit magnitude by 15-bit divisor, 15-bit quotient
    localparam int QUOT_W    = 15;
    localparam int DIVD_W    = 2 * QUOT_W;
    localparam int DIV_BITS  = 3;
    localparam int DIV_STEPS = QUOT_W / DIV_BITS;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic              op;
        logic signed [15:0] target_0;
        logic signed [15:0] target_1;
        logic signed [15:0] target_2;
        logic signed [15:0] target_3;
        logic signed [15:0] target_4;
        logic signed [15:0] target_5;
        logic signed [15:0] target_6;
        logic signed [15:0] target_7;
    } tdr_in_t;

    typedef struct packed {
        logic signed [15:0] drive_0;
        logic signed [15:0] drive_1;
        logic signed [15:0] drive_2;
        logic signed [15:0] drive_3;
        logic signed [15:0] drive_4;
        logic signed [15:0] drive_5;
        logic signed [15:0] drive_6;
        logic signed [15:0] drive_7;
        logic               overflowing;
    } tdr_out_t;

    typedef struct packed {
        logic load;
        logic step;
    } tdr_div_ctrl_t;

    // Datapath operation of one control word
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_TICK,
        UOP_MAX,
        UOP_CHECK,
        UOP_MUL,
        UOP_DLOAD,
        UOP_DIV,
        UOP_WRITE,
        UOP_EMIT
    } uop_t;

    // Jump condition of one control word
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_ITEM,
        JC_IS_LOAD,
        JC_CH_MORE,
        JC_NO_OVF,
        JC_DIV_MORE,
        JC_OUT_BUSY
    } jcond_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_DISPATCH = 4'd1;
    localparam step_t STEP_TICK     = 4'd2;
    localparam step_t STEP_MAX      = 4'd3;
    localparam step_t STEP_CHECK    = 4'd4;
    localparam step_t STEP_MUL      = 4'd5;
    localparam step_t STEP_DLOAD    = 4'd6;
    localparam step_t STEP_DIV      = 4'd7;
    localparam step_t STEP_WRITE    = 4'd8;
    localparam step_t STEP_EMIT     = 4'd9;
    localparam step_t STEP_LAST     = STEP_EMIT;

    typedef struct packed {
        uop_t   uop;
        jcond_t cond;
        step_t  target;
    } ucw_t;

    // Control store: jump to target when the condition holds, else advance
    // (wrapping from the last step to the first).
    function automatic ucw_t tdr_ucode(input step_t pc);
        ucw_t w;
        case (pc)
            STEP_IDLE:     w = '{UOP_ACCEPT, JC_NO_ITEM,  STEP_IDLE};
            STEP_DISPATCH: w = '{UOP_NOP,    JC_IS_LOAD,  STEP_MAX};
            STEP_TICK:     w = '{UOP_TICK,   JC_ALWAYS,   STEP_EMIT};
            STEP_MAX:      w = '{UOP_MAX,    JC_CH_MORE,  STEP_MAX};
            STEP_CHECK:    w = '{UOP_CHECK,  JC_NO_OVF,   STEP_EMIT};
            STEP_MUL:      w = '{UOP_MUL,    JC_NEVER,    STEP_IDLE};
            STEP_DLOAD:    w = '{UOP_DLOAD,  JC_NEVER,    STEP_IDLE};
            STEP_DIV:      w = '{UOP_DIV,    JC_DIV_MORE, STEP_DIV};
            STEP_WRITE:    w = '{UOP_WRITE,  JC_CH_MORE,  STEP_MUL};
            STEP_EMIT:     w = '{UOP_EMIT,   JC_OUT_BUSY, STEP_EMIT};
            default:       w = '{UOP_NOP,    JC_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tdr_div.sv =====
// Iterative unsigned divider, DIV_BITS quotient bits per cycle while ctrl.step is high.
// Depends on tdr_pkg; instantiated by thrust_desaturate_and_ramp_unit.
`default_nettype none

module tdr_div (
    input  logic                          aclk,
    input  tdr_pkg::tdr_div_ctrl_t        ctrl,
    input  logic [tdr_pkg::DIVD_W-1:0]    dividend,
    input  logic [tdr_pkg::QUOT_W-1:0]    divisor,
    output logic [tdr_pkg::QUOT_W-1:0]    quotient
);
    import tdr_pkg::*;

    // Partial remainder, and dividend bits still to shift in with the
    // quotient growing in from the bottom.
    logic [QUOT_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0] dq_reg,  dq_next;

    always_comb begin
        logic [QUOT_W:0] trial;
        rem_next = rem_reg;
        dq_next  = dq_reg;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial   = {rem_next, dq_next[QUOT_W-1]};
            dq_next = {dq_next[QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                trial      = trial - {1'b0, divisor};
                dq_next[0] = 1'b1;
            end
            rem_next = trial[QUOT_W-1:0];
        end
    end

    // The upper half of the dividend is below the divisor, so the quotient
    // fits in QUOT_W bits.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rem_reg <= dividend[DIVD_W-1:QUOT_W];
            dq_reg  <= dividend[QUOT_W-1:0];
        end else if (ctrl.step) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign quotient = dq_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/thrust_desaturate_and_ramp_unit.sv =====
// Thruster command conditioner: desaturation by rescaling plus slew limiting.
// Depends on tdr_pkg and tdr_div.
`default_nettype none

// Channel   Direction  Transfer rule                     Payload
// s_        in         s_valid & s_ready                 tdr_in_t  (op, target_0..7)
// m_        out        m_valid & m_ready                 tdr_out_t (drive_0..7, overflowing)
// APB       in/out     psel & penable & pwrite & pready  limit @0x0, step @0x4
//
// Item flow (N = CHANNELS): a tick item moves the drives and goes to emit;
// a load item takes the maximum over the N targets, then within the limit stores
// them as goals, or above it has the shared divider take every channel in turn:
// multiply, load, quotient steps and writing the goal, before the result is emitted.
// Reset is synchronous: goals, drives and flag clear, registers take their
// reset values. A result waiting in the output register holds the sequencer
// only at its emit step; the next item is taken once that result has moved on.

module thrust_desaturate_and_ramp_unit #(
    parameter int CHANNELS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  tdr_pkg::tdr_in_t  s_data,

    output logic              m_valid,
    input  logic              m_ready,
    output tdr_pkg::tdr_out_t m_data,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tdr_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [14:0] limit_reg;
    logic [14:0] step_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            step_reg  <= STEP_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LIMIT: limit_reg <= pwdata[14:0];
                REG_STEP:  step_reg  <= pwdata[14:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LIMIT: prdata = {17'd0, limit_reg};
            REG_STEP:  prdata = {17'd0, step_reg};
            default:   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: step counter addressing the control store
    // ---------------------------------------------------------------
    step_t pc_reg, pc_next;
    ucw_t  ucw;
    logic  taken;

    // Datapath state
    tdr_in_t                  in_reg;
    logic                     in_load;
    logic [CH_W-1:0]          ch_reg, ch_next, ch_adv;
    logic signed [15:0]       max_reg, max_next;
    logic                     flag_reg, flag_next;
    logic                     neg_reg, neg_next;
    logic [DIVD_W-1:0]        prod_reg, prod_next;
    logic [DCNT_W-1:0]        dcnt_reg, dcnt_next;
    logic signed [15:0]       goal_reg  [CHANNELS];
    logic signed [15:0]       goal_next [CHANNELS];
    logic signed [15:0]       drive_reg  [CHANNELS];
    logic signed [15:0]       drive_next [CHANNELS];
    logic signed [15:0]       tick_val   [CHANNELS];
    tdr_out_t                 out_reg, out_next;
    logic                     m_valid_reg, m_valid_next;

    logic signed [15:0]       tgt [MAXCH];
    logic signed [15:0]       tgt_sel;
    logic [15:0]              tgt_mag;
    logic [30:0]              mul_full;
    logic                     ovf_now;
    logic                     out_busy;
    logic [QUOT_W-1:0]        quot;
    logic [15:0]              quot_ext;
    logic signed [15:0]       drv_ext [MAXCH];
    tdr_div_ctrl_t            div_ctrl;

    assign ucw      = tdr_ucode(pc_reg);
    assign s_ready  = (pc_reg == STEP_IDLE);
    assign out_busy = m_valid_reg && !m_ready;
    assign ovf_now  = max_reg > $signed({1'b0, limit_reg});
    assign ch_adv   = (ch_reg == LAST_CH) ? '0 : CH_W'(ch_reg + 1'b1);

    always_comb begin
        case (ucw.cond)
            JC_NEVER:    taken = 1'b0;
            JC_ALWAYS:   taken = 1'b1;
            JC_NO_ITEM:  taken = !s_valid;
            JC_IS_LOAD:  taken = (in_reg.op == OP_LOAD);
            JC_CH_MORE:  taken = (ch_reg != LAST_CH);
            JC_NO_OVF:   taken = !ovf_now;
            JC_DIV_MORE: taken = (dcnt_reg != DCNT_LAST);
            JC_OUT_BUSY: taken = out_busy;
            default:     taken = 1'b0;
        endcase
    end

    always_comb begin
        if (taken) begin
            pc_next = ucw.target;
        end else if (pc_reg == STEP_LAST) begin
            pc_next = STEP_IDLE;
        end else begin
            pc_next = pc_reg + 4'd1;
        end
    end

    // ---------------------------------------------------------------
    // Operand selection
    // ---------------------------------------------------------------
    assign tgt[0] = in_reg.target_0;
    assign tgt[1] = in_reg.target_1;
    assign tgt[2] = in_reg.target_2;
    assign tgt[3] = in_reg.target_3;
    assign tgt[4] = in_reg.target_4;
    assign tgt[5] = in_reg.target_5;
    assign tgt[6] = in_reg.target_6;
    assign tgt[7] = in_reg.target_7;

    assign tgt_sel  = tgt[ch_reg];
    // Magnitude as unsigned: the most negative target maps to 32768
    assign tgt_mag  = tgt_sel[15] ? (~tgt_sel + 16'd1) : tgt_sel;
    assign mul_full = 31'(tgt_mag) * 31'(limit_reg);
    assign quot_ext = {1'b0, quot};

    // Unused channels read as zero on the result
    for (genvar g = 0; g < MAXCH; g++) begin : g_drv
        if (g < CHANNELS) begin : g_used
            assign drv_ext[g] = drive_reg[g];
        end else begin : g_unused
            assign drv_ext[g] = '0;
        end
    end

    // Slew limiter: move each drive toward its goal by at most step_reg
    always_comb begin
        logic signed [16:0] diff;
        logic [16:0]        dmag;
        logic [16:0]        amt;
        logic [16:0]        res;
        for (int i = 0; i < CHANNELS; i++) begin
            diff = {goal_reg[i][15], goal_reg[i]} - {drive_reg[i][15], drive_reg[i]};
            dmag = diff[16] ? 17'(-diff) : diff;
            amt  = (dmag < {2'b00, step_reg}) ? dmag : {2'b00, step_reg};
            if (diff[16]) begin
                res = {drive_reg[i][15], drive_reg[i]} - amt;
            end else begin
                res = {drive_reg[i][15], drive_reg[i]} + amt;
            end
            tick_val[i] = res[15:0];
        end
    end

    // ---------------------------------------------------------------
    // Datapath control, one operation per control word
    // ---------------------------------------------------------------
    always_comb begin
        in_load      = 1'b0;
        ch_next      = ch_reg;
        max_next     = max_reg;
        flag_next    = flag_reg;
        neg_next     = neg_reg;
        prod_next    = prod_reg;
        dcnt_next    = dcnt_reg;
        goal_next    = goal_reg;
        drive_next   = drive_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        div_ctrl     = '0;

        case (ucw.uop)
            UOP_NOP: ;
            UOP_ACCEPT: begin
                // Take the item and rewind the channel pointer
                if (s_valid) begin
                    in_load = 1'b1;
                    ch_next = '0;
                end
            end
            UOP_TICK: begin
                drive_next = tick_val;
            end
            UOP_MAX: begin
                // Signed maximum, one channel per cycle
                if (ch_reg == '0 || tgt_sel > max_reg) begin
                    max_next = tgt_sel;
                end
                ch_next = ch_adv;
            end
            UOP_CHECK: begin
                // Within limit: store targets unchanged
                flag_next = ovf_now;
                if (!ovf_now) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        goal_next[i] = tgt[i];
                    end
                end
            end
            UOP_MUL: begin
                neg_next  = tgt_sel[15];
                prod_next = mul_full[DIVD_W-1:0];
            end
            UOP_DLOAD: begin
                div_ctrl.load = 1'b1;
                dcnt_next     = '0;
            end
            UOP_DIV: begin
                div_ctrl.step = 1'b1;
                dcnt_next     = DCNT_W'(dcnt_reg + 1'b1);
            end
            UOP_WRITE: begin
                // Restore the sign: truncation toward zero
                goal_next[ch_reg] = neg_reg ? (~quot_ext + 16'd1) : quot_ext;
                ch_next           = ch_adv;
            end
            UOP_EMIT: begin
                if (!out_busy) begin
                    out_next.drive_0     = drv_ext[0];
                    out_next.drive_1     = drv_ext[1];
                    out_next.drive_2     = drv_ext[2];
                    out_next.drive_3     = drv_ext[3];
                    out_next.drive_4     = drv_ext[4];
                    out_next.drive_5     = drv_ext[5];
                    out_next.drive_6     = drv_ext[6];
                    out_next.drive_7     = drv_ext[7];
                    out_next.overflowing = flag_reg;
                    m_valid_next         = 1'b1;
                end
            end
            default: ;
        endcase
    end

    tdr_div u_div (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .dividend (prod_reg),
        .divisor  (max_reg[QUOT_W-1:0]),
        .quotient (quot)
    );

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= STEP_IDLE;
            ch_reg      <= '0;
            dcnt_reg    <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                goal_reg[i]  <= '0;
                drive_reg[i] <= '0;
            end
        end else begin
            pc_reg      <= pc_next;
            ch_reg      <= ch_next;
            dcnt_reg    <= dcnt_next;
            flag_reg    <= flag_next;
            m_valid_reg <= m_valid_next;
            goal_reg    <= goal_next;
            drive_reg   <= drive_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_reg <= s_data;
        end
        max_reg  <= max_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
